>>> rtl/gss_pkg.sv
package gss_pkg;

  localparam int unsigned PADDR_W = 3;
  localparam logic [15:0] DEFAULT_ITERATIONS = 16'd1000;
  localparam logic [30:0] TOLERANCE_RESET = 31'd1;
  localparam logic [31:0] GOLD_Q32 = 32'd1640531527;

  typedef enum logic {
    REG_LIMIT = 1'b0,
    REG_TOLERANCE = 1'b1
  } reg_e;

  typedef enum logic {
    OP_START = 1'b0,
    OP_VALUE = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    KIND_EVAL = 2'd0,
    KIND_CONVERGED = 2'd1,
    KIND_LIMIT = 2'd2,
    KIND_UNEXPECTED = 2'd3
  } kind_e;

  typedef struct packed {
    op_e operation;
    logic signed [31:0] lower_bound;
    logic signed [31:0] upper_bound;
    logic signed [31:0] func_value;
  } in_t;

  typedef struct packed {
    kind_e kind;
    logic signed [31:0] point;
  } out_t;

  // |high - low|, never above 2^32 - 1
  function automatic logic [31:0] abs_diff(input logic signed [31:0] lo,
                                           input logic signed [31:0] hi);
    logic signed [32:0] d;
    logic [32:0] m;
    d = {hi[31], hi} - {lo[31], lo};
    m = d[32] ? (33'd0 - d) : d;
    return m[31:0];
  endfunction

endpackage

>>> rtl/gss_step.sv
module gss_step (
  input  logic signed [31:0] low_i,
  input  logic signed [31:0] high_i,
  output logic signed [31:0] left_o,
  output logic signed [31:0] right_o
);

  logic signed [32:0] diff;
  logic               neg;
  logic [31:0]        mag;
  logic [63:0]        prod;
  logic [63:0]        rounded;
  logic [31:0]        step_mag;
  logic [31:0]        step;

  assign diff     = {high_i[31], high_i} - {low_i[31], low_i};
  assign neg      = diff[32];
  assign mag      = gss_pkg::abs_diff(low_i, high_i);
  assign prod     = 64'(mag) * 64'(gss_pkg::GOLD_Q32);
  assign rounded  = prod + 64'h0000_0000_8000_0000;
  assign step_mag = rounded[63:32];
  assign step     = neg ? (32'd0 - step_mag) : step_mag;
  assign left_o   = low_i + $signed(step);
  assign right_o  = high_i - $signed(step);

endmodule

>>> rtl/golden_section_search.sv
// A beat passes the input register, then the result register; the step multiplier and
// compares sit in one stage. One beat per cycle while the result stage is not stalled.
// A waiting result stalls a full input stage; an empty one still takes a new beat.
// Reset: asynchronous, active low; clears the search state to idle, the iteration
// limit to zero (default limit) and the tolerance to one.
module golden_section_search #(
  parameter logic [15:0] DEFAULT_ITERATIONS = gss_pkg::DEFAULT_ITERATIONS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  gss_pkg::in_t                 in_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output gss_pkg::out_t                out_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [gss_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  typedef enum logic [3:0] {
    PH_IDLE       = 4'b0001,
    PH_LEFT_RIGHT = 4'b0010,
    PH_RIGHT      = 4'b0100,
    PH_LEFT       = 4'b1000
  } phase_e;

  logic [15:0] limit_q;
  logic [30:0] tol_q;
  logic        cfg_wr;
  gss_pkg::reg_e cfg_sel;

  logic          s1_valid_q;
  gss_pkg::in_t  s1_q;
  logic          out_valid_q;
  gss_pkg::out_t out_q, res;
  logic          advance, fire;

  logic signed [31:0] low_q, low_d, high_q, high_d;
  logic signed [31:0] il_q, il_d, ir_q, ir_d;
  logic signed [31:0] vl_q, vl_d, vr_q, vr_d;
  logic [15:0]        count_q, count_d;
  phase_e             phase_q, phase_d;

  logic signed [31:0] step_low, step_high, step_left, step_right;
  logic signed [31:0] vl_cmp, vr_cmp, lo_in, hi_in;
  logic signed [32:0] mid_sum;
  logic [15:0]        lim;
  logic               at_limit, converged;

  // configuration
  assign pready  = 1'b1;
  assign cfg_sel = gss_pkg::reg_e'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign prdata  = (cfg_sel == gss_pkg::REG_LIMIT) ? 32'(limit_q) : 32'(tol_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= '0;
      tol_q   <= gss_pkg::TOLERANCE_RESET;
    end else if (cfg_wr) begin
      if (cfg_sel == gss_pkg::REG_LIMIT) begin
        limit_q <= pwdata[15:0];
      end else begin
        tol_q <= pwdata[30:0];
      end
    end
  end

  // pipeline control
  assign advance     = !out_valid_q || out_ready_i;
  assign in_ready_o  = !s1_valid_q || advance;
  assign fire        = s1_valid_q && advance;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_q <= in_i;
    end
    if (fire) begin
      out_q <= res;
    end
  end

  // search step
  gss_step u_step (
    .low_i   (step_low),
    .high_i  (step_high),
    .left_o  (step_left),
    .right_o (step_right)
  );

  assign lim       = (limit_q != 16'd0) ? limit_q : DEFAULT_ITERATIONS;
  assign at_limit  = count_q >= lim;
  assign converged = gss_pkg::abs_diff(low_q, high_q) <= {1'b0, tol_q};
  assign mid_sum   = {low_q[31], low_q} + {high_q[31], high_q};
  assign lo_in     = (s1_q.upper_bound < s1_q.lower_bound) ? s1_q.upper_bound
                                                           : s1_q.lower_bound;
  assign hi_in     = (s1_q.upper_bound < s1_q.lower_bound) ? s1_q.lower_bound
                                                           : s1_q.upper_bound;
  assign vl_cmp    = (phase_q == PH_LEFT) ? s1_q.func_value : vl_q;
  assign vr_cmp    = (phase_q == PH_RIGHT) ? s1_q.func_value : vr_q;

  always_comb begin
    low_d     = low_q;
    high_d    = high_q;
    il_d      = il_q;
    ir_d      = ir_q;
    vl_d      = vl_q;
    vr_d      = vr_q;
    count_d   = count_q;
    phase_d   = phase_q;
    step_low  = low_q;
    step_high = high_q;
    res.kind  = gss_pkg::KIND_EVAL;
    res.point = '0;
    if (s1_q.operation == gss_pkg::OP_START) begin
      step_low  = lo_in;
      step_high = hi_in;
      low_d     = lo_in;
      high_d    = hi_in;
      count_d   = '0;
      il_d      = step_left;
      ir_d      = step_right;
      phase_d   = PH_LEFT_RIGHT;
      res.point = step_left;
    end else begin
      case (phase_q)
        PH_LEFT_RIGHT: begin
          vl_d      = s1_q.func_value;
          phase_d   = PH_RIGHT;
          res.point = ir_q;
        end
        PH_RIGHT, PH_LEFT: begin
          if (phase_q == PH_RIGHT) begin
            vr_d = s1_q.func_value;
          end else begin
            vl_d = s1_q.func_value;
          end
          if (at_limit || converged) begin
            phase_d   = PH_IDLE;
            res.kind  = at_limit ? gss_pkg::KIND_LIMIT : gss_pkg::KIND_CONVERGED;
            res.point = mid_sum[32:1];
          end else begin
            count_d = count_q + 16'd1;
            if (vl_cmp > vr_cmp) begin
              // drop the left part
              step_low  = il_q;
              low_d     = il_q;
              il_d      = ir_q;
              vl_d      = vr_cmp;
              ir_d      = step_right;
              phase_d   = PH_RIGHT;
              res.point = step_right;
            end else if (vl_cmp < vr_cmp) begin
              // drop the right part
              step_high = ir_q;
              high_d    = ir_q;
              ir_d      = il_q;
              vr_d      = vl_cmp;
              il_d      = step_left;
              phase_d   = PH_LEFT;
              res.point = step_left;
            end else begin
              step_low  = il_q;
              step_high = ir_q;
              low_d     = il_q;
              high_d    = ir_q;
              il_d      = step_left;
              ir_d      = step_right;
              phase_d   = PH_LEFT_RIGHT;
              res.point = step_left;
            end
          end
        end
        default: begin
          res.kind  = gss_pkg::KIND_UNEXPECTED;
          res.point = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q   <= '0;
      high_q  <= '0;
      il_q    <= '0;
      ir_q    <= '0;
      vl_q    <= '0;
      vr_q    <= '0;
      count_q <= '0;
      phase_q <= PH_IDLE;
    end else if (fire) begin
      low_q   <= low_d;
      high_q  <= high_d;
      il_q    <= il_d;
      ir_q    <= ir_d;
      vl_q    <= vl_d;
      vr_q    <= vr_d;
      count_q <= count_d;
      phase_q <= phase_d;
    end
  end

  a_final_goes_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && (res.kind == gss_pkg::KIND_CONVERGED || res.kind == gss_pkg::KIND_LIMIT))
    |=> (phase_q == PH_IDLE))
    else $error("final result did not leave the search idle");

  a_start_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && s1_q.operation == gss_pkg::OP_START)
    |=> (phase_q == PH_LEFT_RIGHT && count_q == 16'd0 && out_valid_q
         && out_q.kind == gss_pkg::KIND_EVAL))
    else $error("start beat did not restart the search");

  a_unexpected_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && s1_q.operation == gss_pkg::OP_VALUE && phase_q == PH_IDLE)
    |=> (out_q.kind == gss_pkg::KIND_UNEXPECTED && out_q.point == 32'sd0
         && phase_q == PH_IDLE))
    else $error("value beat while idle was not reported as unexpected");

endmodule
